>>> sv/tbm_pkg.sv
// ----------------------------------------------------------------------------
// tbm_pkg
// Shared types and constants of the sensor bus master.
// ----------------------------------------------------------------------------
package tbm_pkg;

  localparam int unsigned MaxSensorsDef = 28;
  localparam int unsigned IdW = 5;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 30;

  localparam logic [7:0] StartByte = 8'h7E;
  localparam logic [7:0] EscByte = 8'h7D;
  localparam logic [7:0] EscXor = 8'h20;
  localparam logic [7:0] DataFrameType = 8'h10;
  localparam logic [7:0] SumOk = 8'hFF;

  localparam logic [CfgAddrW-1:0] RegEnable = 2'd0;
  localparam logic [CfgAddrW-1:0] RegPollInterval = 2'd1;
  localparam logic [CfgAddrW-1:0] RegWindow = 2'd2;
  localparam logic [CfgAddrW-1:0] RegSkipped = 2'd3;

  localparam logic [15:0] PollIntervalRst = 16'd4000;
  localparam logic [29:0] WindowRst = 30'd5000000;
  localparam logic [IdW-1:0] SkippedRst = 5'h1B;

  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindOther = 2'd1;
  localparam logic [1:0] KindPoll = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic [31:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  sensor_id;
    logic [7:0]  poll_byte;
    logic [7:0]  frame_type;
    logic [15:0] value_id;
    logic [31:0] value;
  } out_item_t;

  function automatic logic [7:0] with_check_bits(logic [4:0] id);
    logic [7:0] r;
    r[4:0] = id;
    r[5] = id[0] ^ id[1] ^ id[2];
    r[6] = id[2] ^ id[3] ^ id[4];
    r[7] = id[0] ^ id[2] ^ id[4];
    return r;
  endfunction

endpackage

>>> sv/tbm_stream_if.sv
// ----------------------------------------------------------------------------
// tbm_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface tbm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/telemetry_bus_master_poll_and_receive.sv
// ----------------------------------------------------------------------------
// telemetry_bus_master_poll_and_receive
// Sensor bus master: byte deframer, found-sensor list and poll scheduler.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_req  | in  | command, rx_byte, now_us
//  out_req | out | kind, sensor_id, poll_byte, frame_type, value_id, value
//  cfg     | in  | cfg_we_i, cfg_addr_i, cfg_data_i (write only)
//
// One request at a time. The last payload byte walks the 8-byte frame memory
// and then the found list to de-duplicate. A poll in round robin reads the
// found list. Reset clears all control state; the memories need no clearing.
// A waiting result in the output register holds the engine until it is taken.
module telemetry_bus_master_poll_and_receive #(
  parameter int unsigned MaxSensors = tbm_pkg::MaxSensorsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tbm_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [tbm_pkg::CfgDataW-1:0]   cfg_data_i,
  tbm_stream_if.sink                     in_req,
  tbm_stream_if.source                   out_req
);
  localparam int unsigned IdxW = (MaxSensors > 1) ? $clog2(MaxSensors) : 1;
  localparam int unsigned CntW = $clog2(MaxSensors + 1);
  localparam logic [tbm_pkg::IdW-1:0] LastId = tbm_pkg::IdW'(MaxSensors - 1);

  typedef enum logic [3:0] {
    StIdle, StSumRd, StSum, StDedupRd, StDedup, StPollRd, StPoll, StOut
  } state_e;

  // configuration
  logic        en_q;
  logic [15:0] intv_q;
  logic [29:0] win_q;
  logic [4:0]  skip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b1;
      intv_q <= tbm_pkg::PollIntervalRst;
      win_q <= tbm_pkg::WindowRst;
      skip_q <= tbm_pkg::SkippedRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tbm_pkg::RegEnable:       en_q <= cfg_data_i[0];
        tbm_pkg::RegPollInterval: intv_q <= cfg_data_i[15:0];
        tbm_pkg::RegWindow:       win_q <= cfg_data_i;
        tbm_pkg::RegSkipped:      skip_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  state_e state_q;
  logic hunt_q, exp_id_q, esc_q;
  logic [3:0] bcnt_q;
  logic [7:0] raw_id_q;
  logic [CntW-1:0] fcnt_q;
  logic [4:0] rr_q, scan_q;
  logic [31:0] next_q, wend_q;
  logic scanning_q, wstart_q;
  logic [5:0] k_q;
  logic [10:0] sum_q;
  logic [7:0] ftype_q;
  logic [15:0] vid_q;
  logic [31:0] val_q;
  logic [4:0] id_q;
  tbm_pkg::out_item_t out_q;
  logic out_v_q;

  // frame byte memory
  logic fm_we;
  logic [2:0] fm_wa, fm_ra;
  logic [7:0] fm_wd, fm_rd;
  tbm_mem #(.Depth(8), .Width(8)) u_frame (
    .clk_i, .we_i(fm_we), .waddr_i(fm_wa), .wdata_i(fm_wd),
    .raddr_i(fm_ra), .rdata_o(fm_rd)
  );

  // found id memory
  logic id_we;
  logic [IdxW-1:0] id_wa, id_ra;
  logic [4:0] id_rd;
  tbm_mem #(.Depth(MaxSensors), .Width(5)) u_found (
    .clk_i, .we_i(id_we), .waddr_i(id_wa), .wdata_i(id_q),
    .raddr_i(id_ra), .rdata_o(id_rd)
  );

  tbm_pkg::in_item_t in_d;
  assign in_d = in_req.data;
  assign in_req.ready = (state_q == StIdle) && !out_v_q;
  assign out_req.valid = out_v_q;
  assign out_req.data = out_q;

  logic in_fire;
  assign in_fire = in_req.valid && in_req.ready;

  // escape-resolved byte
  logic [7:0] b_x;
  assign b_x = esc_q ? (in_d.rx_byte ^ tbm_pkg::EscXor) : in_d.rx_byte;

  // scheduler decision on the accepted call
  logic [31:0] now_in;
  assign now_in = in_d.now_us;
  logic win_hit;
  logic [31:0] dnext, dwin, wend_eff;
  assign dnext = now_in - next_q;
  assign wend_eff = wstart_q ? wend_q : (now_in + 32'(win_q));
  assign dwin = now_in - wend_eff;
  assign win_hit = !dwin[31];

  // next scan id from scan_q
  function automatic logic [4:0] wrap_id(logic [4:0] v);
    return (v > LastId) ? 5'd0 : v;
  endfunction
  logic [4:0] sc0, sc1;
  assign sc0 = wrap_id(scan_q);
  assign sc1 = (sc0 == skip_q) ? wrap_id(sc0 + 5'd1) : sc0;

  // index wraps
  logic [4:0] rr_eff;
  always_comb begin
    rr_eff = rr_q;
    if ({1'b0, rr_q} >= 6'(fcnt_q) || rr_q > LastId) rr_eff = 5'd0;
  end

  logic [7:0] sum_fold;
  assign sum_fold = 8'(sum_q[7:0] + {5'd0, sum_q[10:8]});

  always_comb begin
    fm_we = 1'b0; fm_wa = bcnt_q[2:0]; fm_wd = b_x;
    fm_ra = k_q[2:0];
    id_we = 1'b0; id_wa = fcnt_q[IdxW-1:0];
    id_ra = k_q[IdxW-1:0];
    if (state_q == StPollRd) id_ra = rr_q[IdxW-1:0];
    if (state_q == StIdle && in_fire && en_q && !in_d.command &&
        in_d.rx_byte != tbm_pkg::StartByte && !hunt_q &&
        in_d.rx_byte != tbm_pkg::EscByte && !exp_id_q && bcnt_q < 4'd8) begin
      fm_we = 1'b1;
    end
    if (state_q == StDedup && k_q >= 6'(fcnt_q) &&
        6'(fcnt_q) < 6'(MaxSensors)) begin
      id_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      hunt_q <= 1'b1; exp_id_q <= 1'b0; esc_q <= 1'b0;
      bcnt_q <= '0; raw_id_q <= '0; fcnt_q <= '0;
      rr_q <= '0; scan_q <= '0; next_q <= '0; wend_q <= '0;
      scanning_q <= 1'b1; wstart_q <= 1'b0;
      k_q <= '0; sum_q <= '0; out_v_q <= 1'b0;
      ftype_q <= '0; vid_q <= '0; val_q <= '0; id_q <= '0; out_q <= '0;
    end else begin
      if (out_req.valid && out_req.ready) out_v_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_fire && en_q) begin
            if (!in_d.command) begin
              if (in_d.rx_byte == tbm_pkg::StartByte) begin
                hunt_q <= 1'b0; exp_id_q <= 1'b1; esc_q <= 1'b0; bcnt_q <= '0;
              end else if (!hunt_q) begin
                if (in_d.rx_byte == tbm_pkg::EscByte) begin
                  esc_q <= 1'b1;
                end else begin
                  esc_q <= 1'b0;
                  if (exp_id_q) begin
                    raw_id_q <= b_x; exp_id_q <= 1'b0;
                  end else if (bcnt_q >= 4'd8) begin
                    hunt_q <= 1'b1;
                  end else begin
                    bcnt_q <= bcnt_q + 4'd1;
                    if (bcnt_q == 4'd7) begin
                      hunt_q <= 1'b1;
                      k_q <= '0; sum_q <= '0;
                      state_q <= StSumRd;
                    end
                  end
                end
              end
            end else if (!wstart_q || !dnext[31]) begin
              wstart_q <= 1'b1;
              next_q <= now_in + {16'd0, intv_q};
              if (scanning_q && win_hit && fcnt_q != '0) begin
                scanning_q <= 1'b0;
                rr_q <= '0;
                wend_q <= wend_eff;
                state_q <= StPollRd;
              end else if (scanning_q || fcnt_q == '0) begin
                if (scanning_q && !win_hit) wend_q <= wend_eff;
                else wend_q <= now_in + 32'(win_q);
                scanning_q <= 1'b1;
                scan_q <= wrap_id(sc1 + 5'd1);
                out_q <= '{kind: tbm_pkg::KindPoll, sensor_id: sc1,
                           poll_byte: tbm_pkg::with_check_bits(sc1),
                           frame_type: 8'd0, value_id: 16'd0, value: 32'd0};
                state_q <= StOut;
              end else begin
                wend_q <= wend_eff;
                rr_q <= rr_eff;
                state_q <= StPollRd;
              end
            end
          end
        end
        StSumRd: begin
          k_q <= k_q + 6'd1;
          state_q <= StSum;
        end
        StSum: begin
          sum_q <= sum_q + {3'd0, fm_rd};
          unique case (k_q)
            6'd1: ftype_q <= fm_rd;
            6'd2: vid_q[7:0] <= fm_rd;
            6'd3: vid_q[15:8] <= fm_rd;
            6'd4: val_q[7:0] <= fm_rd;
            6'd5: val_q[15:8] <= fm_rd;
            6'd6: val_q[23:16] <= fm_rd;
            6'd7: val_q[31:24] <= fm_rd;
            default: ;
          endcase
          if (k_q == 6'd8) begin
            state_q <= StDedupRd;
            id_q <= raw_id_q[4:0];
          end else begin
            k_q <= k_q + 6'd1;
          end
        end
        StDedupRd: begin
          if (sum_fold != tbm_pkg::SumOk ||
              tbm_pkg::with_check_bits(raw_id_q[4:0]) != raw_id_q ||
              raw_id_q[4:0] > LastId) begin
            state_q <= StIdle;
          end else begin
            k_q <= '0;
            state_q <= StDedup;
            out_q <= '{kind: (ftype_q == tbm_pkg::DataFrameType) ?
                             tbm_pkg::KindData : tbm_pkg::KindOther,
                       sensor_id: id_q, poll_byte: 8'd0, frame_type: ftype_q,
                       value_id: vid_q, value: val_q};
          end
        end
        StDedup: begin
          // registered read: entry k is compared in StOut once the read lands
          if (k_q >= 6'(fcnt_q)) begin
            if (6'(fcnt_q) < 6'(MaxSensors)) fcnt_q <= fcnt_q + CntW'(1);
            out_v_q <= 1'b1; state_q <= StIdle;
          end else begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (out_q.kind == tbm_pkg::KindPoll) begin
            out_v_q <= 1'b1; state_q <= StIdle;
          end else if (id_rd == id_q) begin
            out_v_q <= 1'b1; state_q <= StIdle;
          end else begin
            k_q <= k_q + 6'd1; state_q <= StDedup;
          end
        end
        StPollRd: state_q <= StPoll;
        StPoll: begin
          rr_q <= rr_q + 5'd1;
          out_q <= '{kind: tbm_pkg::KindPoll, sensor_id: id_rd,
                     poll_byte: tbm_pkg::with_check_bits(id_rd),
                     frame_type: 8'd0, value_id: 16'd0, value: 32'd0};
          out_v_q <= 1'b1; state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

>>> sv/tbm_mem.sv
// ----------------------------------------------------------------------------
// tbm_mem
// One write port, one registered read port memory.
// ----------------------------------------------------------------------------
module tbm_mem #(
  parameter int unsigned Depth = 8,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
